/* design/assert_macros.svh */
// Assertion macros used by the checker file tts_checker.sv.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on the rising clock edge outside reset.
`define TTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a signal holds in the cycle after a condition.
`define TTS_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("hold assertion failed");

`endif

/* design/tts_pkg.sv */
// Types, constants and the series coefficient table of the trig unit.
// Depends on nothing.
package tts_pkg;

  typedef enum logic [1:0] {
    OP_SIN = 2'd0,
    OP_COS = 2'd1,
    OP_TAN = 2'd2,
    OP_COT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } st_e;

  typedef enum logic [1:0] {
    MK_SQ,
    MK_HORN,
    MK_FIN
  } mk_e;

  localparam int WorkFrac = 28;
  localparam int MaxTerms = 12;
  localparam logic signed [63:0] PiQ     = 64'sd843314857;
  localparam logic signed [63:0] HalfPiQ = 64'sd421657428;
  localparam logic signed [63:0] TwoPiQ  = 64'sd1686629713;
  localparam logic signed [31:0] ValMax  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ValMin  = 32'sh8000_0000;

  // Signed 1/(2i+1)! in Q.28.
  function automatic logic signed [63:0] coef(input logic [3:0] idx);
    logic signed [63:0] c;
    case (idx)
      4'd0:    c = 64'sd268435456;
      4'd1:    c = -64'sd44739243;
      4'd2:    c = 64'sd2236962;
      4'd3:    c = -64'sd53261;
      4'd4:    c = 64'sd740;
      4'd5:    c = -64'sd7;
      default: c = 64'sd0;
    endcase
    return c;
  endfunction

endpackage

/* design/trig_taylor_series_unit.sv */
// Top level of the sine/cosine/tangent/cotangent unit.
// Depends on tts_pkg, tts_front, tts_queue and tts_back.
//
// Request channel: req_valid_i with req_stall_o; req_type_i selects sine,
// cosine, tangent or cotangent, angle_i is radians with ANGLE_FRAC_BITS
// fraction bits. A request is taken on a clock edge with valid high and
// stall low; the front end converts the angle and parks it in a two-entry
// queue, so up to two requests are held while the engine works.
// Result channel: out_valid_o with out_stall_i carries value_o (Q7.24),
// overflowed_o and divide_by_zero_o; a stalled result holds steady.
// The engine handles one request at a time. A sine evaluation runs
// range reduction, then Q.28 products on the shared 32x32 multiplier,
// TERM_COUNT+1 products (TERM_COUNT clamped to 1..12), none at exactly pi.
// Tangent and cotangent run two evaluations and a radix-2 divider.
// Reset empties the queue and clears the result valid flag. While the
// receiver stalls, the engine finishes its current request and holds it,
// and the queue keeps taking requests until full.
module trig_taylor_series_unit #(
  parameter int TERM_COUNT = 10,
  parameter int ANGLE_FRAC_BITS = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               overflowed_o,
  output logic               divide_by_zero_o
);

  // width of the Q.28 angle after conversion
  localparam int XW = (ANGLE_FRAC_BITS >= tts_pkg::WorkFrac) ?
                      32 - (ANGLE_FRAC_BITS - tts_pkg::WorkFrac) :
                      32 + (tts_pkg::WorkFrac - ANGLE_FRAC_BITS);
  localparam int QW = XW + 2;

  logic          q_push, q_pop, q_full, q_empty;
  tts_pkg::op_e  f_op;
  logic [XW-1:0] f_x;
  logic [QW-1:0] q_out;

  tts_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .XW(XW)) u_front (
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_type_i  (req_type_i),
    .angle_i     (angle_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_op_o      (f_op),
    .q_x_o       (f_x)
  );

  // hold converted requests until the engine is free
  tts_queue #(.WIDTH(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_op, f_x}),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tts_back #(.TERM_COUNT(TERM_COUNT), .XW(XW)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_op_i           (tts_pkg::op_e'(q_out[QW-1:XW])),
    .q_x_i            (q_out[XW-1:0]),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .value_o          (value_o),
    .overflowed_o     (overflowed_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

/* design/tts_front.sv */
// Front end: take a request, bring the angle to Q.28 and push it to the queue.
// Depends on tts_pkg.
module tts_front #(
  parameter int ANGLE_FRAC_BITS = 28,
  parameter int XW = 32
) (
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic signed [31:0] angle_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output tts_pkg::op_e      q_op_o,
  output logic [XW-1:0]     q_x_o
);

  localparam int Sh = (ANGLE_FRAC_BITS >= tts_pkg::WorkFrac) ?
                      ANGLE_FRAC_BITS - tts_pkg::WorkFrac :
                      tts_pkg::WorkFrac - ANGLE_FRAC_BITS;

  assign req_stall_o = q_full_i;
  assign q_push_o    = req_valid_i && !q_full_i;
  assign q_op_o      = tts_pkg::op_e'(req_type_i);

  // Drop low bits (floor) or append zero bits to reach 28 fraction bits.
  if (ANGLE_FRAC_BITS >= tts_pkg::WorkFrac) begin : g_down
    assign q_x_o = angle_i[31:Sh];
  end else begin : g_up
    assign q_x_o = {angle_i, {Sh{1'b0}}};
  end

endmodule

/* design/tts_queue.sv */
// Two-entry queue between the front end and the evaluation engine.
// Depends on nothing.
module tts_queue #(
  parameter int WIDTH = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/tts_back.sv */
// Evaluation engine: range reduction, Horner series on a shared 32x32
// multiplier, bit-serial division and the result register. Depends on tts_pkg.
module tts_back #(
  parameter int TERM_COUNT = 10,
  parameter int XW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  tts_pkg::op_e       q_op_i,
  input  logic [XW-1:0]      q_x_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               overflowed_o,
  output logic               divide_by_zero_o
);

  localparam int NT = (TERM_COUNT > tts_pkg::MaxTerms) ? tts_pkg::MaxTerms :
                      (TERM_COUNT < 1) ? 1 : TERM_COUNT;
  localparam logic [3:0] LastIdx = 4'(NT - 1);

  tts_pkg::st_e state_q, state_d;
  tts_pkg::op_e op_q, op_d;
  tts_pkg::mk_e mk_q, mk_d;
  logic signed [63:0] x0_q, x0_d, x_q, x_d, u_q, u_d, s_q, s_d, sn_q, sn_d;
  logic [63:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  idx_q, idx_d;
  logic        second_q, second_d;
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic signed [31:0] res_q, res_d;
  logic        rovf_q, rovf_d, rdz_q, rdz_d;
  logic        ov_q, ov_d, ovf_q, ovf_d, odz_q, odz_d;
  logic signed [31:0] oval_q, oval_d;

  // shared datapath terms
  logic signed [63:0] ma, mb, mr, fin_val, num, dn, nsh, t24;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, acc_sum, nmag, dmag;
  logic [64:0] shr, trial, q65;
  logic        fin, pi_hit, red_done, mul_last, dbit, out_free, div_last;
  logic [63:0] qmag;

  assign out_free = !ov_q || !out_stall_i;
  assign red_done = (state_q == tts_pkg::ST_RED) && (cnt_q == 3'd4);
  assign pi_hit   = red_done && (x_q == tts_pkg::PiQ);
  assign mul_last = (state_q == tts_pkg::ST_MUL) && (cnt_q == 3'd3);
  assign fin      = pi_hit || (mul_last && (mk_q == tts_pkg::MK_FIN));
  assign div_last = (state_q == tts_pkg::ST_DIV) && (dcnt_q == 6'd63);

  // operand select for the product in flight
  always_comb begin
    case (mk_q)
      tts_pkg::MK_SQ:   begin ma = x_q; mb = x_q; end
      tts_pkg::MK_HORN: begin ma = s_q; mb = u_q; end
      default:          begin ma = s_q; mb = x_q; end
    endcase
    mul_a   = (cnt_q == 3'd1) ? ma[63:32] : ma[31:0];
    mul_b   = (cnt_q == 3'd2) ? mb[63:32] : mb[31:0];
    prod    = {32'd0, mul_a} * {32'd0, mul_b};
    acc_sum = acc_q + 64'(64'sd1 <<< (tts_pkg::WorkFrac - 1));
    mr      = $signed(acc_sum) >>> tts_pkg::WorkFrac;
    fin_val = pi_hit ? 64'sd0 : mr;
    t24     = (fin_val + 64'sd8) >>> 4;
    num     = (op_q == tts_pkg::OP_TAN) ? sn_q : fin_val;
    dn      = (op_q == tts_pkg::OP_TAN) ? fin_val : sn_q;
    nsh     = num <<< 24;
    nmag    = nsh[63] ? 64'(-nsh) : 64'(nsh);
    dmag    = dn[63] ? 64'(-dn) : 64'(dn);
    shr     = {rem_q, quo_q[63]};
    trial   = shr - {1'b0, den_q};
    dbit    = !trial[64];
    qmag    = {quo_q[62:0], dbit};
    q65     = neg_q ? 65'(-{1'b0, qmag}) : {1'b0, qmag};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tts_pkg::ST_IDLE: if (!q_empty_i) state_d = tts_pkg::ST_RED;
      tts_pkg::ST_RED: begin
        if (pi_hit) begin
          if (op_q == tts_pkg::OP_SIN || op_q == tts_pkg::OP_COS || !second_q) begin
            state_d = (op_q == tts_pkg::OP_SIN || op_q == tts_pkg::OP_COS) ?
                      tts_pkg::ST_OUT : tts_pkg::ST_RED;
          end else begin
            state_d = (dn == 64'sd0) ? tts_pkg::ST_OUT : tts_pkg::ST_DIV;
          end
        end else if (red_done) begin
          state_d = tts_pkg::ST_MUL;
        end
      end
      tts_pkg::ST_MUL: begin
        if (fin) begin
          if (op_q == tts_pkg::OP_SIN || op_q == tts_pkg::OP_COS) begin
            state_d = tts_pkg::ST_OUT;
          end else if (!second_q) begin
            state_d = tts_pkg::ST_RED;
          end else begin
            state_d = (dn == 64'sd0) ? tts_pkg::ST_OUT : tts_pkg::ST_DIV;
          end
        end
      end
      tts_pkg::ST_DIV: if (div_last) state_d = tts_pkg::ST_OUT;
      tts_pkg::ST_OUT: if (out_free) state_d = tts_pkg::ST_IDLE;
      default: state_d = tts_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop_o  = (state_q == tts_pkg::ST_IDLE) && !q_empty_i;
    op_d = op_q; mk_d = mk_q; x0_d = x0_q; x_d = x_q; u_d = u_q; s_d = s_q;
    sn_d = sn_q; acc_d = acc_q; cnt_d = cnt_q; idx_d = idx_q; second_d = second_q;
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q; dcnt_d = dcnt_q;
    res_d = res_q; rovf_d = rovf_q; rdz_d = rdz_q;
    ov_d = ov_q && out_stall_i; ovf_d = ovf_q; odz_d = odz_q; oval_d = oval_q;

    case (state_q)
      tts_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          op_d     = q_op_i;
          x0_d     = 64'($signed(q_x_i));
          x_d      = (q_op_i == tts_pkg::OP_COS) ?
                     tts_pkg::HalfPiQ - 64'($signed(q_x_i)) : 64'($signed(q_x_i));
          cnt_d    = 3'd0;
          second_d = 1'b0;
        end
      end
      tts_pkg::ST_RED: begin
        // two steps down by 2*pi, then two steps up
        if (cnt_q < 3'd2 && x_q > tts_pkg::PiQ) begin
          x_d = x_q - tts_pkg::TwoPiQ;
        end else if (cnt_q >= 3'd2 && cnt_q < 3'd4 && x_q < -tts_pkg::PiQ) begin
          x_d = x_q + tts_pkg::TwoPiQ;
        end
        cnt_d = cnt_q + 3'd1;
        if (red_done) begin
          cnt_d = 3'd0;
          mk_d  = tts_pkg::MK_SQ;
        end
      end
      tts_pkg::ST_MUL: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd0) begin
          acc_d = prod;
        end else if (cnt_q != 3'd3) begin
          acc_d = acc_q + {prod[31:0], 32'd0};
        end else begin
          cnt_d = 3'd0;
          case (mk_q)
            tts_pkg::MK_SQ: begin
              u_d = mr;
              s_d = tts_pkg::coef(LastIdx);
              if (LastIdx == 4'd0) begin
                mk_d = tts_pkg::MK_FIN;
              end else begin
                mk_d  = tts_pkg::MK_HORN;
                idx_d = LastIdx - 4'd1;
              end
            end
            tts_pkg::MK_HORN: begin
              s_d = tts_pkg::coef(idx_q) + mr;
              if (idx_q == 4'd0) mk_d = tts_pkg::MK_FIN;
              else idx_d = idx_q - 4'd1;
            end
            default: ;
          endcase
        end
      end
      tts_pkg::ST_DIV: begin
        rem_d  = dbit ? trial[63:0] : shr[63:0];
        quo_d  = qmag;
        dcnt_d = dcnt_q + 6'd1;
        if (div_last) begin
          rdz_d = 1'b0;
          if ($signed(q65) > 65'($signed(tts_pkg::ValMax))) begin
            res_d = tts_pkg::ValMax; rovf_d = 1'b1;
          end else if ($signed(q65) < 65'($signed(tts_pkg::ValMin))) begin
            res_d = tts_pkg::ValMin; rovf_d = 1'b1;
          end else begin
            res_d = q65[31:0]; rovf_d = 1'b0;
          end
        end
      end
      tts_pkg::ST_OUT: begin
        if (out_free) begin
          ov_d = 1'b1; oval_d = res_q; ovf_d = rovf_q; odz_d = rdz_q;
        end
      end
      default: ;
    endcase

    // a sine evaluation just finished: route its value
    if (fin) begin
      cnt_d = 3'd0;
      if (op_q == tts_pkg::OP_SIN || op_q == tts_pkg::OP_COS) begin
        res_d = t24[31:0]; rovf_d = 1'b0; rdz_d = 1'b0;
      end else if (!second_q) begin
        sn_d     = fin_val;
        second_d = 1'b1;
        x_d      = tts_pkg::HalfPiQ - x0_q;
      end else if (dn == 64'sd0) begin
        res_d  = num[63] ? tts_pkg::ValMin : tts_pkg::ValMax;
        rovf_d = 1'b1;
        rdz_d  = 1'b1;
      end else begin
        quo_d  = nmag;
        den_d  = dmag;
        rem_d  = 64'd0;
        neg_d  = nsh[63] ^ dn[63];
        dcnt_d = 6'd0;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign value_o          = oval_q;
  assign overflowed_o     = ovf_q;
  assign divide_by_zero_o = odz_q;

  always_ff @(posedge clk_i) begin
    op_q <= op_d; mk_q <= mk_d; x0_q <= x0_d; x_q <= x_d; u_q <= u_d; s_q <= s_d;
    sn_q <= sn_d; acc_q <= acc_d; idx_q <= idx_d; second_q <= second_d;
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d; dcnt_q <= dcnt_d;
    res_q <= res_d; rovf_q <= rovf_d; rdz_q <= rdz_d;
    oval_q <= oval_d; ovf_q <= ovf_d; odz_q <= odz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tts_pkg::ST_IDLE;
      cnt_q   <= 3'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

endmodule

/* design/tts_checker.sv */
// Port-level checks for the trig unit, bound to its top level.
// Depends on assert_macros.svh and tts_pkg.
`include "assert_macros.svh"

module tts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input logic signed [31:0] value_i,
  input logic               overflowed_i,
  input logic               divide_by_zero_i
);

  `TTS_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, value_i)
  `TTS_ASSERT(a_dz_ovf, clk_i, rst_ni, out_valid_i && divide_by_zero_i |-> overflowed_i)
  `TTS_ASSERT(a_ovf_sat, clk_i, rst_ni, out_valid_i && overflowed_i |-> value_i == tts_pkg::ValMax || value_i == tts_pkg::ValMin)
  `TTS_ASSERT(a_out_stay, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i)

endmodule

bind trig_taylor_series_unit tts_checker u_tts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .value_i          (value_o),
  .overflowed_i     (overflowed_o),
  .divide_by_zero_i (divide_by_zero_o)
);
